### design/gbfp_pkg.sv
// Package for the GNSS binary frame parser.
// Holds the shared types, result codes, register indexes and CRC helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gbfp_pkg;

  localparam logic [7:0]  SyncByte0 = 8'hAA;
  localparam logic [7:0]  SyncByte1 = 8'h44;
  localparam logic [7:0]  SyncByte2 = 8'h12;
  localparam logic [31:0] CrcPoly   = 32'hEDB88320;

  localparam logic [2:0] KindPayload = 3'd0;
  localparam logic [2:0] KindGood    = 3'd1;
  localparam logic [2:0] KindCrcErr  = 3'd2;
  localparam logic [2:0] KindBadHdr  = 3'd3;
  localparam logic [2:0] KindZeroLen = 3'd4;

  localparam int CfgIndexW = 2;
  localparam logic [CfgIndexW-1:0] CfgHeaderLength = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgCrcEnable    = 2'd1;

  localparam logic [7:0] HeaderLengthReset = 8'd28;

  typedef struct packed {
    logic [7:0] header_length;
    logic       crc_check_enable;
  } cfg_t;

  typedef struct packed {
    logic [15:0] msg_id;
    logic [7:0]  log_type;
    logic [15:0] msg_len;
    logic [15:0] seq_num;
    logic [7:0]  time_status;
    logic [15:0] week;
    logic [31:0] time_ms;
    logic [31:0] rx_status;
  } hdr_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic [15:0] byte_index;
    hdr_t        hdr;
    logic [31:0] computed_crc;
  } result_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] sync_byte(logic [1:0] idx);
    case (idx)
      2'd0:    sync_byte = SyncByte0;
      2'd1:    sync_byte = SyncByte1;
      default: sync_byte = SyncByte2;
    endcase
  endfunction

  // Header bytes are little endian; each lane is written once per frame.
  function automatic hdr_t capture(hdr_t h, logic [15:0] pos, logic [7:0] b);
    capture = h;
    case (pos)
      16'd4:   capture.msg_id[7:0]       = h.msg_id[7:0] | b;
      16'd5:   capture.msg_id[15:8]      = h.msg_id[15:8] | b;
      16'd6:   capture.log_type          = b;
      16'd8:   capture.msg_len[7:0]      = h.msg_len[7:0] | b;
      16'd9:   capture.msg_len[15:8]     = h.msg_len[15:8] | b;
      16'd10:  capture.seq_num[7:0]      = h.seq_num[7:0] | b;
      16'd11:  capture.seq_num[15:8]     = h.seq_num[15:8] | b;
      16'd13:  capture.time_status       = b;
      16'd14:  capture.week[7:0]         = h.week[7:0] | b;
      16'd15:  capture.week[15:8]        = h.week[15:8] | b;
      16'd16:  capture.time_ms[7:0]      = h.time_ms[7:0] | b;
      16'd17:  capture.time_ms[15:8]     = h.time_ms[15:8] | b;
      16'd18:  capture.time_ms[23:16]    = h.time_ms[23:16] | b;
      16'd19:  capture.time_ms[31:24]    = h.time_ms[31:24] | b;
      16'd20:  capture.rx_status[7:0]    = h.rx_status[7:0] | b;
      16'd21:  capture.rx_status[15:8]   = h.rx_status[15:8] | b;
      16'd22:  capture.rx_status[23:16]  = h.rx_status[23:16] | b;
      16'd23:  capture.rx_status[31:24]  = h.rx_status[31:24] | b;
      default: capture = h;
    endcase
  endfunction

endpackage

`default_nettype wire

### design/gbfp_core.sv
// Frame state machine, header capture and running CRC for the frame parser.
// Processes one byte per step and flags the result it produces.
// Depends on gbfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbfp_core
  import gbfp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,
  input  wire logic [7:0] byte_i,
  input  wire cfg_t    cfg_i,
  output logic         res_valid_o,
  output result_t      res_o
);

  localparam logic [1:0] PhSync = 2'd0;
  localparam logic [1:0] PhHdr  = 2'd1;
  localparam logic [1:0] PhPay  = 2'd2;
  localparam logic [1:0] PhCrc  = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] rcrc_q, rcrc_d;
  hdr_t        hdr_q, hdr_d;

  logic [31:0] crc_upd, crc_first;
  logic [16:0] pos_inc;
  logic [1:0]  sync_pos, crc_pos;
  logic        ends;
  logic        emit;
  logic [2:0]  kind;
  logic [7:0]  val;
  logic [15:0] idx;
  logic [31:0] crc_out;

  assign crc_upd   = crc_byte(crc_q, byte_i);
  assign crc_first = crc_byte(32'd0, byte_i);
  assign pos_inc   = {1'b0, pos_q} + 17'd1;
  assign sync_pos  = (pos_q > 16'd2) ? 2'd0 : pos_q[1:0];
  assign crc_pos   = (pos_q > 16'd3) ? 2'd3 : pos_q[1:0];
  assign ends      = (pos_inc >= {9'd0, cfg_i.header_length});

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    rcrc_d  = rcrc_q;
    hdr_d   = hdr_q;
    emit    = 1'b0;
    kind    = KindPayload;
    val     = 8'd0;
    idx     = 16'd0;
    crc_out = 32'd0;
    case (phase_q)
      PhSync: begin
        if (byte_i != sync_byte(sync_pos)) begin
          pos_d = 16'd0;
        end else begin
          crc_d = (sync_pos == 2'd0) ? crc_first : crc_upd;
          pos_d = {14'd0, sync_pos} + 16'd1;
          if (sync_pos == 2'd2) begin
            hdr_d   = '0;
            rcrc_d  = 32'd0;
            phase_d = PhHdr;
          end
        end
      end
      PhHdr: begin
        if ((pos_q == 16'd3) && (byte_i != cfg_i.header_length)) begin
          phase_d = PhSync;
          pos_d   = 16'd0;
          emit    = 1'b1;
          kind    = KindBadHdr;
        end else begin
          if (pos_q != 16'd3) begin
            hdr_d = capture(hdr_q, pos_q, byte_i);
          end
          crc_d = crc_upd;
          if (((pos_q == 16'd9) || ends) && (hdr_d.msg_len == 16'd0)) begin
            phase_d = PhSync;
            pos_d   = 16'd0;
            emit    = 1'b1;
            kind    = KindZeroLen;
          end else if (ends) begin
            phase_d = PhPay;
            pos_d   = 16'd0;
          end else begin
            pos_d = pos_inc[15:0];
          end
        end
      end
      PhPay: begin
        crc_d = crc_upd;
        pos_d = pos_inc[15:0];
        if (pos_inc[15:0] >= hdr_q.msg_len) begin
          phase_d = PhCrc;
          pos_d   = 16'd0;
          rcrc_d  = 32'd0;
        end
        emit = 1'b1;
        kind = KindPayload;
        val  = byte_i;
        idx  = pos_q;
      end
      default: begin
        rcrc_d[{crc_pos, 3'b000} +: 8] = rcrc_q[{crc_pos, 3'b000} +: 8] | byte_i;
        if (crc_pos == 2'd3) begin
          phase_d = PhSync;
          pos_d   = 16'd0;
          emit    = 1'b1;
          kind    = (cfg_i.crc_check_enable && (rcrc_d != crc_q)) ? KindCrcErr : KindGood;
          crc_out = crc_q;
        end else begin
          pos_d = {14'd0, crc_pos} + 16'd1;
        end
      end
    endcase
  end

  assign res_valid_o        = step_i && emit;
  assign res_o.kind         = kind;
  assign res_o.byte_value   = val;
  assign res_o.byte_index   = idx;
  assign res_o.hdr          = hdr_d;
  assign res_o.computed_crc = crc_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSync;
      pos_q   <= 16'd0;
      crc_q   <= 32'd0;
      rcrc_q  <= 32'd0;
      hdr_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      rcrc_q  <= rcrc_d;
      hdr_q   <= hdr_d;
    end
  end

endmodule

`default_nettype wire

### design/gbfp_out_reg.sv
// Result register for the frame parser output channel.
// Holds one result transaction until the receiver takes it.
// Depends on gbfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbfp_out_reg
  import gbfp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  input  wire logic    out_stall_i,
  output logic         blocked_o,
  output logic         valid_o,
  output result_t      res_o
);

  logic    valid_q;
  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign blocked_o = valid_q && out_stall_i;
  assign valid_o   = valid_q;
  assign res_o     = res_q;

endmodule

`default_nettype wire

### design/gnss_binary_frame_parser_top.sv
// Top level of the GNSS binary frame parser: input register, configuration
// registers, frame core and result register; depends on gbfp_pkg, gbfp_core, gbfp_out_reg.
// Each byte is registered at the input and its result is registered at the output.
// Throughput: one byte per cycle when not stalled, set by the byte-wide CRC update.
// Reset: asynchronous, clears both channels, returns to sync hunting and
// loads header_length 28 and crc_check_enable 1.
`timescale 1ns / 1ps
`default_nettype none

module gnss_binary_frame_parser_top
  import gbfp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           rx_byte_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [7:0]           cfg_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [2:0]                kind_o,
  output logic [7:0]                byte_value_o,
  output logic [15:0]               byte_index_o,
  output logic [15:0]               msg_id_o,
  output logic [7:0]                log_type_o,
  output logic [15:0]               msg_len_o,
  output logic [15:0]               seq_num_o,
  output logic [7:0]                time_status_o,
  output logic [15:0]               week_o,
  output logic [31:0]               time_ms_o,
  output logic [31:0]               rx_status_o,
  output logic [31:0]               computed_crc_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  cfg_t       cfg_q;
  logic       blocked;
  logic       advance;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign advance    = in_valid_q && !blocked;
  assign in_stall_o = in_valid_q && blocked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_length    <= HeaderLengthReset;
      cfg_q.crc_check_enable <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgHeaderLength: cfg_q.header_length    <= cfg_data_i;
        CfgCrcEnable:    cfg_q.crc_check_enable <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  gbfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  gbfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .blocked_o   (blocked),
    .valid_o     (out_valid_o),
    .res_o       (out_res)
  );

  assign kind_o         = out_res.kind;
  assign byte_value_o   = out_res.byte_value;
  assign byte_index_o   = out_res.byte_index;
  assign msg_id_o       = out_res.hdr.msg_id;
  assign log_type_o     = out_res.hdr.log_type;
  assign msg_len_o      = out_res.hdr.msg_len;
  assign seq_num_o      = out_res.hdr.seq_num;
  assign time_status_o  = out_res.hdr.time_status;
  assign week_o         = out_res.hdr.week;
  assign time_ms_o      = out_res.hdr.time_ms;
  assign rx_status_o    = out_res.hdr.rx_status;
  assign computed_crc_o = out_res.computed_crc;

endmodule

`default_nettype wire

### design/gbfp_checker.sv
// Port-level checker for the GNSS binary frame parser, with its bind.
// Depends on gbfp_pkg and gnss_binary_frame_parser_top.
`timescale 1ns / 1ps
`default_nettype none

module gbfp_checker
  import gbfp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  kind_o,
  input wire logic [7:0]  byte_value_o,
  input wire logic [15:0] byte_index_o,
  input wire logic [31:0] computed_crc_o
);

  // The input side only stalls when a result is held by the receiver.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stall without a blocked result");

  a_frame_end_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o != KindPayload)) |->
      ((byte_value_o == 8'd0) && (byte_index_o == 16'd0)))
    else $error("frame result carries payload byte data");

  a_abort_no_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((kind_o == KindBadHdr) || (kind_o == KindZeroLen) ||
                     (kind_o == KindPayload))) |-> (computed_crc_o == 32'd0))
    else $error("CRC reported on a result without a completed frame");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_hold_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(kind_o) && $stable(computed_crc_o) && $stable(byte_index_o)))
    else $error("stalled result changed");

endmodule

bind gnss_binary_frame_parser_top gbfp_checker u_checker (.*);

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for gnss_binary_frame_parser_top: streams frames, sync noise and
// register changes with random gaps and output stalls, and checks each result against a
// byte-level frame parser model. Depends on gbfp_pkg and the design sources.

module testbench;
  import gbfp_pkg::*;

  typedef enum logic [1:0] {ScanSync, InHeader, InPayload, InCrc} parse_phase_e;

  localparam logic [7:0]           Sync0 = 8'hAA;
  localparam logic [7:0]           Sync1 = 8'h44;
  localparam logic [7:0]           Sync2 = 8'h12;
  localparam logic [31:0]          Crc32Poly = 32'hEDB88320;
  localparam logic [7:0]           DefaultHeaderLength = 8'd28;
  localparam logic [CfgIndexW-1:0] CfgSpareIndexA = 2'd2;
  localparam logic [CfgIndexW-1:0] CfgSpareIndexB = 2'd3;
  localparam int                   DrainCycles = 4;
  localparam int                   RandomBytes = 150;
  localparam int                   MaxPrinted = 100;
  localparam int                   TimeoutNs = 1_000_000;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic [7:0]           rx_byte = 8'h00;
  logic                 cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = 8'h00;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [2:0]           kind;
  logic [7:0]           byte_value;
  logic [15:0]          byte_index;
  logic [15:0]          msg_id;
  logic [7:0]           log_type;
  logic [15:0]          msg_len;
  logic [15:0]          seq_num;
  logic [7:0]           time_status;
  logic [15:0]          week;
  logic [31:0]          time_ms;
  logic [31:0]          rx_status;
  logic [31:0]          computed_crc;

  logic [7:0]   cfg_hdr_len;
  logic         cfg_crc_on;
  parse_phase_e parse_phase;
  logic [15:0]  offset;
  logic [31:0]  crc_accum;
  logic [31:0]  crc_rx;
  hdr_t         frame_hdr;

  result_t expected_results[$];
  int      mismatch_count = 0;
  int      live_bytes = 0;
  bit      steady_flow = 1'b0;

  gnss_binary_frame_parser_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .byte_value_o   (byte_value),
    .byte_index_o   (byte_index),
    .msg_id_o       (msg_id),
    .log_type_o     (log_type),
    .msg_len_o      (msg_len),
    .seq_num_o      (seq_num),
    .time_status_o  (time_status),
    .week_o         (week),
    .time_ms_o      (time_ms),
    .rx_status_o    (rx_status),
    .computed_crc_o (computed_crc)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int pick_gap();
    int roll;
    if (steady_flow) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 4);
  endfunction

  function automatic logic [31:0] crc32_update(logic [31:0] acc, logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'h0, b};
    repeat (8) c = (c >> 1) ^ (Crc32Poly & {32{c[0]}});
    return c;
  endfunction

  function automatic result_t make_result(logic [2:0] k, logic [7:0] v, logic [15:0] idx,
                                          logic [31:0] crc);
    result_t r;
    r.kind = k;
    r.byte_value = v;
    r.byte_index = idx;
    r.hdr = frame_hdr;
    r.computed_crc = crc;
    return r;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output result_t res);
    logic [15:0] pos;
    logic [7:0]  want_sync;
    bit          ends;
    pos = offset;
    res = '0;
    case (parse_phase)
      ScanSync: begin
        if (pos > 16'd2) pos = '0;
        want_sync = (pos == 16'd0) ? Sync0 : (pos == 16'd1) ? Sync1 : Sync2;
        if (b != want_sync) begin
          offset = '0;
          return 1'b0;
        end
        if (pos == 16'd0) crc_accum = '0;
        crc_accum = crc32_update(crc_accum, b);
        offset = pos + 16'd1;
        if (offset == 16'd3) begin
          frame_hdr = '0;
          crc_rx = '0;
          parse_phase = InHeader;
        end
        return 1'b0;
      end
      InHeader: begin
        if (pos == 16'd3) begin
          if (b != cfg_hdr_len) begin
            parse_phase = ScanSync;
            offset = '0;
            res = make_result(KindBadHdr, 8'h00, 16'h0000, 32'h0);
            return 1'b1;
          end
        end else begin
          case (pos)
            16'd4:   frame_hdr.msg_id[7:0] = b;
            16'd5:   frame_hdr.msg_id[15:8] = b;
            16'd6:   frame_hdr.log_type = b;
            16'd8:   frame_hdr.msg_len[7:0] = b;
            16'd9:   frame_hdr.msg_len[15:8] = b;
            16'd10:  frame_hdr.seq_num[7:0] = b;
            16'd11:  frame_hdr.seq_num[15:8] = b;
            16'd13:  frame_hdr.time_status = b;
            16'd14:  frame_hdr.week[7:0] = b;
            16'd15:  frame_hdr.week[15:8] = b;
            16'd16, 16'd17, 16'd18, 16'd19:
              frame_hdr.time_ms |= 32'(b) << (8 * (pos - 16'd16));
            16'd20, 16'd21, 16'd22, 16'd23:
              frame_hdr.rx_status |= 32'(b) << (8 * (pos - 16'd20));
            default: ;
          endcase
        end
        crc_accum = crc32_update(crc_accum, b);
        ends = (32'(pos) + 1 >= 32'(cfg_hdr_len));
        if ((pos == 16'd9 || ends) && frame_hdr.msg_len == 16'd0) begin
          parse_phase = ScanSync;
          offset = '0;
          res = make_result(KindZeroLen, 8'h00, 16'h0000, 32'h0);
          return 1'b1;
        end
        if (ends) begin
          parse_phase = InPayload;
          offset = '0;
        end else begin
          offset = pos + 16'd1;
        end
        return 1'b0;
      end
      InPayload: begin
        crc_accum = crc32_update(crc_accum, b);
        offset = pos + 16'd1;
        if (offset >= frame_hdr.msg_len) begin
          parse_phase = InCrc;
          offset = '0;
          crc_rx = '0;
        end
        res = make_result(KindPayload, b, pos, 32'h0);
        return 1'b1;
      end
      default: begin
        if (pos > 16'd3) pos = 16'd3;
        crc_rx |= 32'(b) << (8 * pos);
        if (pos == 16'd3) begin
          res = make_result((cfg_crc_on && crc_rx != crc_accum) ? KindCrcErr : KindGood,
                            8'h00, 16'h0000, crc_accum);
          parse_phase = ScanSync;
          offset = '0;
          return 1'b1;
        end
        offset = pos + 16'd1;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count < MaxPrinted) $display("%0t mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result of kind %0d with none expected", kind));
      return;
    end
    want = expected_results.pop_front();
    compare_field("kind", kind, want.kind);
    compare_field("byte_value", byte_value, want.byte_value);
    compare_field("byte_index", byte_index, want.byte_index);
    compare_field("msg_id", msg_id, want.hdr.msg_id);
    compare_field("log_type", log_type, want.hdr.log_type);
    compare_field("msg_len", msg_len, want.hdr.msg_len);
    compare_field("seq_num", seq_num, want.hdr.seq_num);
    compare_field("time_status", time_status, want.hdr.time_status);
    compare_field("week", week, want.hdr.week);
    compare_field("time_ms", time_ms, want.hdr.time_ms);
    compare_field("rx_status", rx_status, want.hdr.rx_status);
    compare_field("computed_crc", computed_crc, want.computed_crc);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) check_result();
  end

  initial begin
    int hold;
    forever begin
      hold = pick_gap();
      out_stall <= (hold != 0);
      repeat ((hold == 0) ? $urandom_range(6, 1) : hold) @(posedge clk);
    end
  end

  task automatic send_byte(logic [7:0] b);
    int      gap;
    result_t res;
    bit      got;
    gap = pick_gap();
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (!in_valid) in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    got = parse_byte(b, res);
    if (got) expected_results.push_back(res);
    if (got || parse_phase != ScanSync) live_bytes++;
  endtask

  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [7:0] data);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgHeaderLength) cfg_hdr_len = data;
    else if (idx == CfgCrcEnable) cfg_crc_on = data[0];
  endtask

  // Builds a frame for the current header length; bytes before index first are not sent.
  task automatic send_frame(logic [7:0] len_byte, logic [15:0] payload_len, bit bad_crc,
                            int first = 0);
    logic [7:0]  frame[$];
    logic [31:0] crc;
    int          hdr_bytes;
    hdr_bytes = (cfg_hdr_len > 8'd4) ? int'(cfg_hdr_len) : 4;
    frame = '{Sync0, Sync1, Sync2, len_byte};
    for (int p = 4; p < hdr_bytes; p++) begin
      if (p == 8) frame.push_back(payload_len[7:0]);
      else if (p == 9) frame.push_back(payload_len[15:8]);
      else frame.push_back(8'($urandom));
    end
    repeat (payload_len) frame.push_back(8'($urandom));
    crc = '0;
    foreach (frame[i]) crc = crc32_update(crc, frame[i]);
    if (bad_crc) crc ^= 32'(1) << $urandom_range(31);
    for (int i = 0; i < 4; i++) frame.push_back(crc[8*i +: 8]);
    for (int i = first; i < frame.size(); i++) send_byte(frame[i]);
  endtask

  task automatic test_reset_values();
    send_frame(DefaultHeaderLength, 16'd5, 1'b0);
    send_frame(DefaultHeaderLength, 16'd3, 1'b1);
  endtask

  task automatic test_sync_hunting();
    logic [7:0] noise[$];
    noise = '{8'h00, 8'hFF, Sync0, Sync0, Sync1, Sync2, Sync0, Sync1, 8'h55,
              Sync0, Sync1, Sync2, 8'hFF, 8'h00};
    foreach (noise[i]) send_byte(noise[i]);
  endtask

  task automatic test_zero_length();
    send_frame(DefaultHeaderLength, 16'd0, 1'b0);
  endtask

  task automatic test_crc_disable();
    write_reg(CfgCrcEnable, 8'h00);
    send_frame(cfg_hdr_len, 16'd4, 1'b1);
    write_reg(CfgCrcEnable, 8'h01);
  endtask

  task automatic test_header_length_extremes();
    write_reg(CfgHeaderLength, 8'd255);
    send_byte(Sync0);
    send_byte(Sync1);
    send_byte(Sync2);
    send_byte(8'd254);
    write_reg(CfgHeaderLength, 8'd64);
    send_frame(8'd64, 16'd2, 1'b0);
    write_reg(CfgHeaderLength, 8'd0);
    send_frame(8'd0, 16'd3, 1'b0);
    write_reg(CfgHeaderLength, 8'd10);
    send_frame(8'd10, 16'd6, 1'b0);
    write_reg(CfgHeaderLength, 8'd9);
    send_frame(8'd9, 16'd7, 1'b0);
  endtask

  task automatic test_spare_index();
    write_reg(CfgSpareIndexA, 8'h00);
    write_reg(CfgSpareIndexB, 8'hFF);
    send_frame(cfg_hdr_len, 16'd2, 1'b1);
  endtask

  task automatic test_write_mid_frame();
    write_reg(CfgHeaderLength, DefaultHeaderLength);
    send_byte(Sync0);
    send_byte(Sync1);
    send_byte(Sync2);
    write_reg(CfgHeaderLength, 8'd20);
    send_frame(8'd20, 16'd5, 1'b0, 3);
  endtask

  task automatic pick_settings();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) write_reg(CfgHeaderLength, 8'($urandom_range(32, 24)));
    else if (roll < 80) write_reg(CfgHeaderLength, 8'($urandom_range(23, 10)));
    else if (roll < 90) write_reg(CfgHeaderLength, 8'($urandom_range(9, 0)));
    else if (roll < 98) write_reg(CfgHeaderLength, 8'($urandom_range(64, 33)));
    else write_reg(CfgHeaderLength, 8'($urandom_range(255, 200)));
    if ($urandom_range(1)) write_reg(CfgCrcEnable, 8'($urandom));
  endtask

  task automatic test_random_traffic();
    int          start;
    int          roll;
    logic [15:0] plen;
    start = live_bytes;
    while (live_bytes - start < RandomBytes) begin
      if ($urandom_range(4) == 0) pick_settings();
      steady_flow = ($urandom_range(7) == 0);
      roll = $urandom_range(99);
      plen = 16'($urandom_range(12, 1));
      if (roll >= 85) plen = 16'($urandom_range(40, 13));
      if (roll >= 97) plen = 16'($urandom_range(300, 256));
      roll = $urandom_range(99);
      if (roll < 70) begin
        send_frame(cfg_hdr_len, plen, 1'b0);
      end else if (roll < 80) begin
        send_frame(cfg_hdr_len, plen, 1'b1);
      end else if (roll < 85) begin
        send_frame(cfg_hdr_len ^ 8'($urandom_range(255, 1)), plen, 1'b0);
      end else if (roll < 90) begin
        send_frame(cfg_hdr_len, 16'd0, 1'b0);
      end else begin
        if ($urandom_range(1)) send_byte(Sync0);
        if ($urandom_range(1)) send_byte(Sync1);
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
        send_byte(8'h00);
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    cfg_hdr_len = DefaultHeaderLength;
    cfg_crc_on = 1'b1;
    parse_phase = ScanSync;
    offset = '0;
    crc_accum = '0;
    crc_rx = '0;
    frame_hdr = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_sync_hunting();
    test_zero_length();
    test_crc_disable();
    test_header_length_extremes();
    test_spare_index();
    test_write_mid_frame();
    test_random_traffic();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("** gnss_binary_frame_parser_top: PASSED **");
    end else begin
      $display("** gnss_binary_frame_parser_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #TimeoutNs;
    $display("** gnss_binary_frame_parser_top: FAILED **");
    $finish;
  end

endmodule
